[src/elpso_pkg.sv]
// ----------------------------------------------------------------------------
// elpso_pkg: shared types and constants
// Opcodes, widths and the pattern push struct passed from the front end to the queue.
// ----------------------------------------------------------------------------
package elpso_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int PATTERN_BITS    = 8;
    localparam int LEVEL_W         = 6;
    localparam int BIT_CNT_W       = 3;
    localparam logic [LEVEL_W-1:0] MAX_LEVEL_RESET = 6'd20;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_SET      = 2'd1,
        OP_EXCL_ON  = 2'd2,
        OP_SET_ALL  = 2'd3
    } opcode_t;

    typedef struct packed {
        logic                    valid;
        logic [PATTERN_BITS-1:0] pattern;
    } pat_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

[src/elpso_front.sv]
// ----------------------------------------------------------------------------
// elpso_front: item decode, duty table and level counter
// Applies duty updates and, on a tick, builds the pattern and pushes it.
// ----------------------------------------------------------------------------
module elpso_front #(
    parameter int CHANNELS = elpso_pkg::CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                fire,
    input  logic [1:0]                          opcode,
    input  logic [2:0]                          channel,
    input  logic signed [7:0]                   intensity,
    input  logic [elpso_pkg::LEVEL_W-1:0]       max_level,
    output elpso_pkg::pat_push_t                push
);

    localparam int PAT_CH = (CHANNELS < elpso_pkg::PATTERN_BITS) ?
                            CHANNELS : elpso_pkg::PATTERN_BITS;

    logic [elpso_pkg::LEVEL_W-1:0] duty_reg  [CHANNELS];
    logic [elpso_pkg::LEVEL_W-1:0] duty_next [CHANNELS];
    logic [elpso_pkg::LEVEL_W-1:0] level_reg, level_next;
    logic [elpso_pkg::LEVEL_W-1:0] clamped;
    logic [elpso_pkg::LEVEL_W:0]   level_inc;
    logic [elpso_pkg::PATTERN_BITS-1:0] pat;
    logic                          ch_ok;
    elpso_pkg::opcode_t            op;

    assign op = elpso_pkg::opcode_t'(opcode);
    assign ch_ok = (int'(channel) < CHANNELS);

    // clamp signed request into 0..max_level
    always_comb
    begin
        if (intensity[7])
            clamped = '0;
        else if (intensity[6:0] > {1'b0, max_level})
            clamped = max_level;
        else
            clamped = intensity[elpso_pkg::LEVEL_W-1:0];
    end

    always_comb
    begin
        pat = '0;
        for (int i = 0; i < PAT_CH; i++)
        begin
            pat[elpso_pkg::PATTERN_BITS-1-i] = (level_reg < duty_reg[i]);
        end
    end

    assign level_inc = {1'b0, level_reg} + 7'd1;

    always_comb
    begin
        level_next = level_reg;
        for (int i = 0; i < CHANNELS; i++)
        begin
            duty_next[i] = duty_reg[i];
        end
        if (fire)
        begin
            unique case (op)
                elpso_pkg::OP_TICK:
                begin
                    if (level_inc >= {1'b0, max_level})
                        level_next = '0;
                    else
                        level_next = level_inc[elpso_pkg::LEVEL_W-1:0];
                end
                elpso_pkg::OP_SET:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        if (ch_ok && (int'(channel) == i))
                            duty_next[i] = clamped;
                    end
                end
                elpso_pkg::OP_EXCL_ON:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        duty_next[i] = (ch_ok && (int'(channel) == i)) ? max_level : '0;
                    end
                end
                elpso_pkg::OP_SET_ALL:
                begin
                    for (int i = 0; i < CHANNELS; i++)
                    begin
                        duty_next[i] = clamped;
                    end
                end
                default:
                begin
                    level_next = level_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                duty_reg[i] <= '0;
            end
        end
        else
        begin
            level_reg <= level_next;
            for (int i = 0; i < CHANNELS; i++)
            begin
                duty_reg[i] <= duty_next[i];
            end
        end
    end

    assign push.valid   = fire && (op == elpso_pkg::OP_TICK);
    assign push.pattern = pat;

endmodule

[src/elpso_queue.sv]
// ----------------------------------------------------------------------------
// elpso_queue: two-entry pattern queue
// Decouples tick acceptance from the serial shifter.
// ----------------------------------------------------------------------------
module elpso_queue (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  elpso_pkg::pat_push_t                  push,
    input  logic                                  pop,
    output logic [elpso_pkg::PATTERN_BITS-1:0]    head,
    output elpso_pkg::queue_stat_t                stat
);

    logic [elpso_pkg::PATTERN_BITS-1:0] mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push.valid;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push.valid} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem[wr_ptr_reg] <= push.pattern;
    end

    assign head       = mem[rd_ptr_reg];
    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);

endmodule

[src/elpso_shift.sv]
// ----------------------------------------------------------------------------
// elpso_shift: serial shifter
// Sends each queued pattern as eight beats, MSB first, latch on the last.
// ----------------------------------------------------------------------------
module elpso_shift (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [elpso_pkg::PATTERN_BITS-1:0]    head,
    input  elpso_pkg::queue_stat_t                stat,
    output logic                                  pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  serial_bit,
    output logic [elpso_pkg::PATTERN_BITS-1:0]    pattern,
    output logic                                  latch
);

    logic [elpso_pkg::PATTERN_BITS-1:0] shift_reg, shift_next;
    logic [elpso_pkg::PATTERN_BITS-1:0] pat_reg, pat_next;
    logic [elpso_pkg::BIT_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                               busy_reg, busy_next;
    logic                               last, out_fire;

    assign last     = (cnt_reg == {elpso_pkg::BIT_CNT_W{1'b1}});
    assign out_fire = busy_reg && out_ready;
    // load when idle or when the last beat leaves, if the queue holds a pattern
    assign pop      = !stat.empty && (!busy_reg || (out_fire && last));

    always_comb
    begin
        shift_next = shift_reg;
        pat_next   = pat_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        if (pop)
        begin
            shift_next = head;
            pat_next   = head;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (out_fire)
        begin
            shift_next = {shift_reg[elpso_pkg::PATTERN_BITS-2:0], 1'b0};
            cnt_next   = cnt_reg + 1'b1;
            busy_next  = !last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        pat_reg   <= pat_next;
    end

    assign out_valid  = busy_reg;
    assign serial_bit = shift_reg[elpso_pkg::PATTERN_BITS-1];
    assign pattern    = pat_reg;
    assign latch      = last;

endmodule

[src/eight_channel_led_pwm_shift_out.sv]
// ----------------------------------------------------------------------------
// eight_channel_led_pwm_shift_out: eight-channel LED PWM with serial output
// Path: with the shifter idle, a tick's pattern is written into the queue,
// then loaded into the shifter, which presents the pattern's first beat.
// Throughput: one item per cycle at the input while the two-entry pattern
// queue has room; ticks drain as out_ready takes each pattern's eight beats.
// Reset: duties and level clear to zero, max_level returns to 20, queue empty.
// ----------------------------------------------------------------------------
module eight_channel_led_pwm_shift_out #(
    parameter int CHANNELS = elpso_pkg::CHANNELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [1:0]                            opcode,
    input  logic [2:0]                            channel,
    input  logic signed [7:0]                     intensity,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  serial_bit,
    output logic [elpso_pkg::PATTERN_BITS-1:0]    pattern,
    output logic                                  latch,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [elpso_pkg::LEVEL_W-1:0]         cfg_data
);

    logic [elpso_pkg::LEVEL_W-1:0]      max_level_reg, max_level_next;
    logic [elpso_pkg::PATTERN_BITS-1:0] head;
    elpso_pkg::pat_push_t               push;
    elpso_pkg::queue_stat_t             stat;
    logic                               pop;
    logic                               fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = !stat.full;
    assign fire      = in_valid && in_ready;

    assign max_level_next = (cfg_valid && cfg_ready) ? cfg_data : max_level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_level_reg <= elpso_pkg::MAX_LEVEL_RESET;
        else
            max_level_reg <= max_level_next;
    end

    elpso_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .opcode    (opcode),
        .channel   (channel),
        .intensity (intensity),
        .max_level (max_level_reg),
        .push      (push)
    );

    elpso_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .stat  (stat)
    );

    elpso_shift u_shift (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .stat       (stat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .serial_bit (serial_bit),
        .pattern    (pattern),
        .latch      (latch)
    );

endmodule
